[design/cq_pkg.sv]
// ---------------------------------------------------------------------------
// cq_pkg
// Shared types and constants for the ring queue with search operations.
// ---------------------------------------------------------------------------
package cq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Operation codes carried in a request
    localparam logic [OP_W-1:0] OP_ENQ        = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ        = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_EVN = 3'd3;
    localparam logic [OP_W-1:0] OP_DOUBLE     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] data;
    } cq_in_t;

    typedef struct packed {
        logic                     accepted;
        logic [CNT_W-1:0]         match_count;
        logic signed [DATA_W-1:0] head_value;
        logic                     is_empty;
        logic                     is_full;
    } cq_out_t;

    // Memory bank control from the sequencer to the bank logic
    typedef struct packed {
        logic rd_en;   // read both banks at the read address
        logic wr_en;   // write at the write address
        logic wr_alt;  // write goes to the inactive bank
        logic flip;    // inactive bank becomes the active one
    } cq_mem_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_WR,
        ST_HEAD_RD,
        ST_DONE
    } cq_state_t;

endpackage

[design/circular_queue_with_search_ops_top.sv]
// ---------------------------------------------------------------------------
// circular_queue_with_search_ops_top
// Ring queue of signed words with enqueue, dequeue and search operations.
// ---------------------------------------------------------------------------
// One request is processed at a time. Enqueue, dequeue and unknown
// operations go from acceptance through a head read to the result.
// Remove-first-match, remove-even and double-matches scan the live entries
// through the slot memory read port, a read step and a write step per
// entry. The slots live in two memory banks: compacting operations write
// survivors in order into the inactive bank and then swap banks. A result
// waits in an output register while the next request is already being
// worked on. Slots need no clearing after reset.
module circular_queue_with_search_ops_top #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  cq_pkg::cq_in_t            in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output cq_pkg::cq_out_t           out_item,
    input  logic                      cfg_we,
    input  logic [cq_pkg::DATA_W-1:0] cfg_wdata
);
    import cq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cq_mem_ctl_t       mem_ctl;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] rdata0;
    logic [DATA_W-1:0] rdata1;
    logic              bank_sel_reg;
    logic              wr_bank;

    // Track the active bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_sel_reg <= 1'b0;
        end
        else if (mem_ctl.flip)
        begin
            bank_sel_reg <= !bank_sel_reg;
        end
    end

    // Route writes and select read data by bank
    assign wr_bank = bank_sel_reg ^ mem_ctl.wr_alt;
    assign rdata   = bank_sel_reg ? rdata1 : rdata0;

    cq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mem_ctl   (mem_ctl),
        .raddr     (raddr),
        .waddr     (waddr),
        .wdata     (wdata),
        .rdata     (rdata)
    );

    cq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (mem_ctl.wr_en && !wr_bank),
        .waddr (waddr),
        .wdata (wdata),
        .re    (mem_ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata0)
    );

    cq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (mem_ctl.wr_en && wr_bank),
        .waddr (waddr),
        .wdata (wdata),
        .re    (mem_ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata1)
    );

endmodule

[design/cq_ram.sv]
// ---------------------------------------------------------------------------
// cq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cq_ctrl.sv]
// ---------------------------------------------------------------------------
// cq_ctrl
// Sequencer for the ring queue: head and tail pointers, slot scans for the
// search operations, and the result register.
// ---------------------------------------------------------------------------
module cq_ctrl #(
    parameter int DEPTH = cq_pkg::DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  cq_pkg::cq_in_t                         in_item,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output cq_pkg::cq_out_t                        out_item,
    input  logic                                   cfg_we,
    input  logic [cq_pkg::DATA_W-1:0]              cfg_wdata,
    output cq_pkg::cq_mem_ctl_t                    mem_ctl,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    output logic [cq_pkg::DATA_W-1:0]              wdata,
    input  logic [cq_pkg::DATA_W-1:0]              rdata
);
    import cq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        nxt = (i == LAST) ? '0 : i + 1'b1;
    endfunction

    cq_state_t               state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [AW-1:0]           end_reg, end_next;
    logic [AW-1:0]           n_reg, n_next;
    logic                    found_reg, found_next;
    logic                    acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic [DATA_W-1:0]       marker_reg;
    logic                    out_valid_reg, out_valid_next;
    cq_out_t                 out_item_reg, out_item_next;

    logic                    q_empty;
    logic                    q_full;

    assign q_empty = (nxt(tail_reg) == head_reg);
    assign q_full  = (nxt(nxt(tail_reg)) == head_reg);

    // Hold the empty marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= '0;
        end
        else if (cfg_we)
        begin
            marker_reg <= cfg_wdata;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= LAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current request
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        end_reg      <= end_next;
        n_reg        <= n_next;
        found_reg    <= found_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        op_reg       <= op_next;
        data_reg     <= data_next;
        out_item_reg <= out_item_next;
    end

    // Next state, memory accesses and result
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        n_next         = n_reg;
        found_next     = found_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        mem_ctl        = '0;
        raddr          = idx_reg;
        waddr          = n_reg;
        wdata          = rdata;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_item.op;
                    data_next  = in_item.data;
                    acc_next   = 1'b0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    n_next     = '0;
                    idx_next   = head_reg;
                    end_next   = nxt(tail_reg);
                    state_next = ST_HEAD_RD;
                    case (in_item.op)
                        OP_ENQ:
                        begin
                            if (!q_full)
                            begin
                                tail_next     = nxt(tail_reg);
                                mem_ctl.wr_en = 1'b1;
                                waddr         = nxt(tail_reg);
                                wdata         = in_item.data;
                                acc_next      = 1'b1;
                            end
                        end
                        OP_DEQ:
                        begin
                            if (!q_empty)
                            begin
                                head_next = nxt(head_reg);
                                acc_next  = 1'b1;
                            end
                        end
                        OP_REMOVE, OP_REMOVE_EVN, OP_DOUBLE:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = ST_HEAD_RD;
                        end
                    endcase
                end
            end

            ST_SCAN_RD:
            begin
                if (idx_reg == end_reg)
                begin
                    // Scan finished: commit a compaction, if any, by swapping banks
                    if ((op_reg == OP_REMOVE_EVN) || ((op_reg == OP_REMOVE) && found_reg))
                    begin
                        mem_ctl.flip = 1'b1;
                        head_next    = '0;
                        tail_next    = (n_reg != '0) ? n_reg - 1'b1 : LAST;
                        acc_next     = (op_reg == OP_REMOVE);
                    end
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    raddr         = idx_reg;
                    state_next    = ST_SCAN_WR;
                end
            end

            ST_SCAN_WR:
            begin
                case (op_reg)
                    OP_REMOVE:
                    begin
                        if (!found_reg && (rdata == data_reg))
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            mem_ctl.wr_en  = 1'b1;
                            mem_ctl.wr_alt = 1'b1;
                            waddr          = n_reg;
                            n_next         = n_reg + 1'b1;
                        end
                    end
                    OP_REMOVE_EVN:
                    begin
                        if (rdata[0])
                        begin
                            mem_ctl.wr_en  = 1'b1;
                            mem_ctl.wr_alt = 1'b1;
                            waddr          = n_reg;
                            n_next         = n_reg + 1'b1;
                        end
                    end
                    OP_DOUBLE:
                    begin
                        if (rdata == data_reg)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            waddr         = idx_reg;
                            wdata         = {rdata[DATA_W-2:0], 1'b0};
                            if (cnt_reg != CNT_MAX)
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                idx_next   = nxt(idx_reg);
                state_next = ST_SCAN_RD;
            end

            ST_HEAD_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                raddr         = head_reg;
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                // Load the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.accepted    = acc_reg;
                    out_item_next.match_count = cnt_reg;
                    out_item_next.head_value  = q_empty ? marker_reg : rdata;
                    out_item_next.is_empty    = q_empty;
                    out_item_next.is_full     = q_full;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
